/* src/mcdu_pkg.sv */
// Shared types, command and register codes, and sequencer encodings for the
// moment constraint dual update unit. No dependencies.
package mcdu_pkg;

  // Table geometry
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_W    = 10;
  localparam int IDX_EXT_W   = 17;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int NMOM        = 3;
  localparam int COEF_W      = 16;
  localparam int ROW_W       = NMOM * COEF_W;

  // Configuration register indexes
  localparam logic [2:0] REG_RELAX     = 3'd0;
  localparam logic [2:0] REG_STEP_ZERO = 3'd1;
  localparam logic [2:0] REG_STEP_ONE  = 3'd2;
  localparam logic [2:0] REG_STEP_TWO  = 3'd3;
  localparam logic [2:0] REG_BOUND_ZERO = 3'd4;
  localparam logic [2:0] REG_BOUND_ONE = 3'd5;
  localparam logic [2:0] REG_BOUND_TWO = 3'd6;

  // Configuration reset values
  localparam logic [15:0] RELAX_RESET = 16'd32768;
  localparam logic [31:0] STEP_RESET  = 32'd65536;
  localparam logic [31:0] BOUND_RESET = 32'hFFFF_0000;

  typedef logic [NMOM-1:0][COEF_W-1:0] coef3_t;
  typedef logic [NMOM-1:0][31:0]       word3_t;
  typedef logic [1:0]                  mom_t;

  localparam mom_t LAST_MOM = mom_t'(NMOM - 1);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_BACK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_U_LO,
    ST_U_HI,
    ST_U_LIM,
    ST_U_SCALE,
    ST_U_CLAMP1,
    ST_U_CLAMP2,
    ST_U_Z0,
    ST_U_Z1,
    ST_U_D,
    ST_U_FINAL,
    ST_B_MUL,
    ST_B_ADD,
    ST_OUT
  } state_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_CLEAR,
    DP_ACC,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_MUL_LIM,
    DP_SCALE,
    DP_CLAMP1,
    DP_CLAMP2,
    DP_MUL_Z0,
    DP_MUL_Z1,
    DP_MUL_D,
    DP_FINAL,
    DP_BMUL,
    DP_BADD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    mom_t   mom;
  } dp_ctrl_t;

endpackage

/* src/mcdu_coef_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the per-sample coefficient rows. No dependencies.
module mcdu_coef_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/mcdu_datapath.sv */
// Arithmetic core: moment accumulators, dual registers, shared multiplier and
// the clamp / relax pipeline steps. Depends on mcdu_pkg.
module mcdu_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mcdu_pkg::dp_ctrl_t  ctrl,
  input  mcdu_pkg::coef3_t    coef,
  input  logic signed [15:0]  wave,
  input  logic [15:0]         relax,
  input  mcdu_pkg::word3_t    step,
  input  mcdu_pkg::word3_t    bound,
  output mcdu_pkg::word3_t    dual,
  output logic signed [47:0]  back
);
  import mcdu_pkg::*;

  // Saturate to signed 47 bits
  function automatic logic [46:0] sat47(input logic [79:0] x);
    logic [46:0] r;
    if (&x[79:46] || ~|x[79:46]) begin
      r = x[46:0];
    end else if (x[79]) begin
      r = {1'b1, 46'd0};
    end else begin
      r = {1'b0, {46{1'b1}}};
    end
    return r;
  endfunction

  // Saturate a 49-bit sum to signed 48 bits
  function automatic logic [47:0] sat48(input logic [48:0] x);
    logic [47:0] r;
    if (x[48] == x[47]) begin
      r = x[47:0];
    end else if (x[48]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  // Saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic [79:0] x);
    logic [31:0] r;
    if (&x[79:31] || ~|x[79:31]) begin
      r = x[31:0];
    end else if (x[79]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  logic signed [47:0] sums  [NMOM];
  logic signed [31:0] duals [NMOM];
  logic signed [31:0] wprod [NMOM];
  logic signed [65:0] product;
  logic signed [79:0] acc;
  logic signed [47:0] bval;
  logic signed [47:0] lim;
  logic signed [55:0] b100;
  logic signed [55:0] l99;
  logic signed [46:0] zval;

  logic        [31:0] step_sel;
  logic signed [31:0] bound_sel;
  logic signed [47:0] sum_sel;
  logic signed [31:0] dual_sel;
  logic signed [15:0] coef_sel;
  logic signed [16:0] rest;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [79:0] prod80;
  logic signed [46:0] qsat;
  logic signed [47:0] bnext;
  logic signed [55:0] b56;
  logic signed [55:0] l56;
  logic signed [55:0] b100_next;
  logic signed [55:0] l99_next;
  logic signed [47:0] cval;
  logic signed [48:0] diff;
  logic signed [46:0] zsat;
  logic signed [79:0] fsum;
  logic signed [31:0] dnew;

  // Per-moment selection
  always_comb begin
    step_sel  = step[ctrl.mom];
    bound_sel = $signed(bound[ctrl.mom]);
    sum_sel   = sums[ctrl.mom];
    dual_sel  = duals[ctrl.mom];
    coef_sel  = $signed(coef[ctrl.mom]);
    rest      = 17'sd32768 - $signed({1'b0, relax});
  end

  // Shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      DP_MUL_LO: begin
        ma = {1'b0, step_sel};
        mb = {9'd0, sum_sel[23:0]};
      end
      DP_MUL_HI: begin
        ma = {1'b0, step_sel};
        mb = {{9{sum_sel[47]}}, sum_sel[47:24]};
      end
      DP_MUL_LIM: begin
        ma = {1'b0, step_sel};
        mb = {bound_sel[31], bound_sel};
      end
      DP_MUL_Z0: begin
        ma = {17'd0, relax};
        mb = {9'd0, zval[23:0]};
      end
      DP_MUL_Z1: begin
        ma = {17'd0, relax};
        mb = {{10{zval[46]}}, zval[46:24]};
      end
      DP_MUL_D: begin
        ma = {{16{rest[16]}}, rest};
        mb = {dual_sel[31], dual_sel};
      end
      DP_BMUL: begin
        ma = {{17{coef_sel[15]}}, coef_sel};
        mb = {dual_sel[31], dual_sel};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Update arithmetic between registers
  always_comb begin
    prod80    = {{14{product[65]}}, product};
    qsat      = sat47(acc >>> 28);
    bnext     = {{16{dual_sel[31]}}, dual_sel} + {qsat[46], qsat};
    b56       = {{8{bval[47]}}, bval};
    l56       = {{8{lim[47]}}, lim};
    b100_next = (b56 <<< 6) + (b56 <<< 5) + (b56 <<< 2);
    l99_next  = (l56 <<< 6) + (l56 <<< 5) + (l56 <<< 1) + l56;
    if (b100 > l99) begin
      cval = lim;
    end else if (b100 < -l99) begin
      cval = -lim;
    end else begin
      cval = bval;
    end
    diff = {bval[47], bval} - {cval[47], cval};
    zsat = sat47({{31{diff[48]}}, diff});
    fsum = acc + prod80;
    dnew = sat32(fsum >>> 15);
  end

  // Working registers
  always_ff @(posedge clk) begin
    product <= ma * mb;
    case (ctrl.op)
      DP_MUL_HI:  acc <= prod80;
      DP_MUL_LIM: acc <= acc + (prod80 <<< 24);
      DP_SCALE: begin
        bval <= bnext;
        lim  <= product[63:16];
      end
      DP_CLAMP1: begin
        b100 <= b100_next;
        l99  <= l99_next;
      end
      DP_CLAMP2:  zval <= zsat;
      DP_MUL_Z1:  acc <= prod80;
      DP_MUL_D:   acc <= acc + (prod80 <<< 24);
      default: begin
      end
    endcase
  end

  // Sample products for accumulation
  always_ff @(posedge clk) begin
    if (ctrl.op == DP_LATCH) begin
      for (int j = 0; j < NMOM; j++) begin
        wprod[j] <= wave * $signed(coef[j]);
      end
    end
  end

  // Moment sums and duals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NMOM; j++) begin
        sums[j]  <= '0;
        duals[j] <= '0;
      end
      back <= '0;
    end else begin
      case (ctrl.op)
        DP_LATCH: back <= '0;
        DP_CLEAR: begin
          for (int j = 0; j < NMOM; j++) begin
            duals[j] <= '0;
          end
          back <= '0;
        end
        DP_ACC: begin
          for (int j = 0; j < NMOM; j++) begin
            sums[j] <= sat48({sums[j][47], sums[j]} + {{17{wprod[j][31]}}, wprod[j]});
          end
        end
        DP_FINAL: begin
          duals[ctrl.mom] <= dnew;
          sums[ctrl.mom]  <= '0;
        end
        DP_BADD: begin
          if (!bound_sel[31]) begin
            back <= back + product[47:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < NMOM; j++) begin
      dual[j] = duals[j];
    end
  end

endmodule

/* src/moment_constraint_dual_update_unit.sv */
// Top level of the moment constraint dual update unit: handshakes, config
// registers, control sequencer, output register. Uses mcdu_pkg,
// mcdu_coef_ram and mcdu_datapath.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    cmd, sample_index, coef_*, wave_value,
//                                              last_sample
//  output    out        out_valid / out_stall  dual_*, back_term, updated
//  config    in         cfg_write              cfg_index, cfg_data
//
// One transaction at a time. Load and clear run only the read step, accumulate
// adds the accumulate step, back-project a multiply and add per moment, and
// accumulate with last_sample the update: ten steps per moment on one shared
// 33x33 multiplier. Coefficient rows come from a registered RAM read issued at acceptance.
// Synchronous reset clears duals, sums, config and control; the coefficient
// RAM is not cleared. A stalled result sits in the output register while the
// next transaction is accepted and processed.
module moment_constraint_dual_update_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [9:0]         sample_index,
  input  logic signed [15:0] coef_zero,
  input  logic signed [15:0] coef_one,
  input  logic signed [15:0] coef_two,
  input  logic signed [15:0] wave_value,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] dual_zero,
  output logic signed [31:0] dual_one,
  output logic signed [31:0] dual_two,
  output logic signed [47:0] back_term,
  output logic               updated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import mcdu_pkg::*;

  state_t   state;
  state_t   state_next;
  mom_t     mom;
  mom_t     mom_next;
  dp_ctrl_t ctrl;

  logic        accept;
  logic        load;
  logic        in_range;
  logic [IDX_EXT_W-1:0] idx_ext;

  cmd_t               cmd_q;
  logic signed [15:0] wave_q;
  logic               last_q;
  logic               ok_q;

  logic [15:0] relax;
  word3_t      step;
  word3_t      bound;

  logic [ROW_W-1:0] row_rd;
  coef3_t           coef_use;
  word3_t           dual_w;
  logic signed [47:0] back_w;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign idx_ext  = IDX_EXT_W'(sample_index);
  assign in_range = (idx_ext < IDX_EXT_W'(MAX_SAMPLES));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      relax <= RELAX_RESET;
      for (int j = 0; j < NMOM; j++) begin
        step[j]  <= STEP_RESET;
        bound[j] <= BOUND_RESET;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RELAX:      relax    <= cfg_data[15:0];
        REG_STEP_ZERO:  step[0]  <= cfg_data;
        REG_STEP_ONE:   step[1]  <= cfg_data;
        REG_STEP_TWO:   step[2]  <= cfg_data;
        REG_BOUND_ZERO: bound[0] <= cfg_data;
        REG_BOUND_ONE:  bound[1] <= cfg_data;
        REG_BOUND_TWO:  bound[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(cmd);
      wave_q <= wave_value;
      last_q <= last_sample;
      ok_q   <= in_range;
    end
  end

  // Coefficient table
  mcdu_coef_ram #(
    .DEPTH  (MAX_SAMPLES),
    .DATA_W (ROW_W),
    .ADDR_W (ADDR_W)
  ) u_coef_ram (
    .clk   (clk),
    .we    (accept && in_range && (cmd_t'(cmd) == CMD_LOAD)),
    .waddr (idx_ext[ADDR_W-1:0]),
    .wdata ({coef_two, coef_one, coef_zero}),
    .re    (accept),
    .raddr (idx_ext[ADDR_W-1:0]),
    .rdata (row_rd)
  );

  // Out-of-range rows read as zero
  assign coef_use = ok_q ? coef3_t'(row_rd) : '0;

  mcdu_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .coef  (coef_use),
    .wave  (wave_q),
    .relax (relax),
    .step  (step),
    .bound (bound),
    .dual  (dual_w),
    .back  (back_w)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mom   <= '0;
    end else begin
      state <= state_next;
      mom   <= mom_next;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next = state;
    mom_next   = mom;
    ctrl.op    = DP_NONE;
    ctrl.mom   = mom;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ctrl.op  = (cmd_q == CMD_CLEAR) ? DP_CLEAR : DP_LATCH;
        mom_next = '0;
        case (cmd_q)
          CMD_ACCUM: state_next = ST_ACC;
          CMD_BACK:  state_next = ST_B_MUL;
          default:   state_next = ST_OUT;
        endcase
      end
      ST_ACC: begin
        ctrl.op    = DP_ACC;
        state_next = last_q ? ST_U_LO : ST_OUT;
      end
      ST_U_LO: begin
        ctrl.op    = DP_MUL_LO;
        state_next = ST_U_HI;
      end
      ST_U_HI: begin
        ctrl.op    = DP_MUL_HI;
        state_next = ST_U_LIM;
      end
      ST_U_LIM: begin
        ctrl.op    = DP_MUL_LIM;
        state_next = ST_U_SCALE;
      end
      ST_U_SCALE: begin
        ctrl.op    = DP_SCALE;
        state_next = ST_U_CLAMP1;
      end
      ST_U_CLAMP1: begin
        ctrl.op    = DP_CLAMP1;
        state_next = ST_U_CLAMP2;
      end
      ST_U_CLAMP2: begin
        ctrl.op    = DP_CLAMP2;
        state_next = ST_U_Z0;
      end
      ST_U_Z0: begin
        ctrl.op    = DP_MUL_Z0;
        state_next = ST_U_Z1;
      end
      ST_U_Z1: begin
        ctrl.op    = DP_MUL_Z1;
        state_next = ST_U_D;
      end
      ST_U_D: begin
        ctrl.op    = DP_MUL_D;
        state_next = ST_U_FINAL;
      end
      ST_U_FINAL: begin
        ctrl.op = DP_FINAL;
        if (mom == LAST_MOM) begin
          state_next = ST_OUT;
        end else begin
          mom_next   = mom + 2'd1;
          state_next = ST_U_LO;
        end
      end
      ST_B_MUL: begin
        ctrl.op    = DP_BMUL;
        state_next = ST_B_ADD;
      end
      ST_B_ADD: begin
        ctrl.op = DP_BADD;
        if (mom == LAST_MOM) begin
          state_next = ST_OUT;
        end else begin
          mom_next   = mom + 2'd1;
          state_next = ST_B_MUL;
        end
      end
      ST_OUT: begin
        load = !out_valid || !out_stall;
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dual_zero <= $signed(dual_w[0]);
      dual_one  <= $signed(dual_w[1]);
      dual_two  <= $signed(dual_w[2]);
      back_term <= back_w;
      updated   <= (cmd_q == CMD_ACCUM) && last_q;
    end
  end

  // An accepted transaction always starts with the table read
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted transaction did not enter the read step");

  // The last moment of an update ends the sequence
  a_update_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_U_FINAL && mom == LAST_MOM) |=> state == ST_OUT)
    else $error("dual update did not finish after the last moment");

  // A clear command leaves all duals at zero when its result is formed
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && cmd_q == CMD_CLEAR) |->
      (dual_w[0] == '0 && dual_w[1] == '0 && dual_w[2] == '0))
    else $error("duals not cleared by clear command");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && state == ST_IDLE))
    else $error("result load did not raise out_valid");

endmodule

/* bench/tb_moment_constraint_dual_update_unit.sv */
// Self-checking bench for moment_constraint_dual_update_unit: a scoreboard class
// predicts duals, back-projection and update flag per transaction.
// Depends on mcdu_pkg and the unit's RTL only.
module tb_moment_constraint_dual_update_unit;
  import mcdu_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 700000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 135;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    word3_t             duals;
    logic signed [47:0] back;
    logic               upd;
  } dual_result_t;

  // Scoreboard: own copy of config, coefficient table, sums and duals
  class dual_scoreboard;
    logic [15:0]        relax;
    logic [31:0]        steps [NMOM];
    logic signed [31:0] bounds [NMOM];
    coef3_t             coef_mem [MAX_SAMPLES];
    logic signed [47:0] sums [NMOM];
    logic signed [31:0] duals [NMOM];
    dual_result_t       expected_q [$];
    string              dual_name [NMOM] = '{"dual_zero", "dual_one", "dual_two"};
    int                 errors;
    int                 checked;
    int                 updates;

    function new();
      relax = RELAX_RESET;
      for (int j = 0; j < NMOM; j++) begin
        steps[j]  = STEP_RESET;
        bounds[j] = BOUND_RESET;
        sums[j]   = '0;
        duals[j]  = '0;
      end
      errors  = 0;
      checked = 0;
      updates = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_RELAX:      relax = data[15:0];
        REG_STEP_ZERO:  steps[0] = data;
        REG_STEP_ONE:   steps[1] = data;
        REG_STEP_TWO:   steps[2] = data;
        REG_BOUND_ZERO: bounds[0] = data;
        REG_BOUND_ONE:  bounds[1] = data;
        REG_BOUND_TWO:  bounds[2] = data;
        default: ;
      endcase
    endfunction

    // Saturate to a signed field of the given width
    function logic signed [127:0] clip(logic signed [127:0] x, int bits);
      logic signed [127:0] hi;
      hi = (128'sd1 <<< (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    // Scale sum by step, add to dual, clamp with the 0.99 rule, over-relax
    function void update_moment(int j);
      logic signed [127:0] q, b, lim, c, z, acc, pw, t;
      t   = sums[j] * $signed({1'b0, steps[j]});
      q   = clip(t >>> 28, 47);
      b   = duals[j] + q;
      lim = ($signed({1'b0, steps[j]}) * bounds[j]) >>> 16;
      if (100 * b > 99 * lim) c = lim;
      else if (100 * b < -99 * lim) c = -lim;
      else c = b;
      z   = clip(b - c, 47);
      pw  = relax;
      acc = pw * z + (32768 - pw) * duals[j];
      t   = clip(acc >>> 15, 32);
      duals[j] = t[31:0];
      sums[j]  = '0;
    endfunction

    // Accepted input transaction: advance state, queue the expected result
    function void note_input(cmd_t op, logic [9:0] idx, coef3_t coefs,
                             logic signed [15:0] wave, logic last);
      dual_result_t        res;
      coef3_t              row;
      logic signed [127:0] acc_w;
      row       = coef_mem[idx];
      res.back  = '0;
      res.upd   = 1'b0;
      acc_w     = '0;
      case (op)
        CMD_LOAD: coef_mem[idx] = coefs;
        CMD_ACCUM: begin
          for (int j = 0; j < NMOM; j++) begin
            acc_w   = sums[j] + wave * $signed(row[j]);
            acc_w   = clip(acc_w, 48);
            sums[j] = acc_w[47:0];
          end
          if (last) begin
            for (int j = 0; j < NMOM; j++) update_moment(j);
            res.upd = 1'b1;
            updates++;
          end
        end
        CMD_BACK: begin
          for (int j = 0; j < NMOM; j++)
            if (bounds[j] >= 0) acc_w = acc_w + $signed(row[j]) * duals[j];
          res.back = acc_w[47:0];
        end
        CMD_CLEAR: begin
          for (int j = 0; j < NMOM; j++) duals[j] = '0;
        end
        default: ;
      endcase
      for (int j = 0; j < NMOM; j++) res.duals[j] = duals[j];
      expected_q.push_back(res);
    endfunction

    // Accepted output transaction: compare against the oldest expectation
    function void check_result(logic signed [31:0] d0, logic signed [31:0] d1,
                               logic signed [31:0] d2, logic signed [47:0] bk,
                               logic up);
      dual_result_t want;
      word3_t       got;
      if (expected_q.size() == 0) begin
        $error("unexpected result: no transaction pending (dual_zero %0d)", d0);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      got  = {d2, d1, d0};
      checked++;
      for (int j = 0; j < NMOM; j++)
        if (got[j] !== want.duals[j]) begin
          $error("%s mismatch: expected %0d, actual %0d", dual_name[j],
                 $signed(want.duals[j]), $signed(got[j]));
          errors++;
        end
      if (bk !== want.back) begin
        $error("back_term mismatch: expected %0d, actual %0d", want.back, bk);
        errors++;
      end
      if (up !== want.upd) begin
        $error("updated mismatch: expected %0d, actual %0d", want.upd, up);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [9:0]         sample_index;
  logic signed [15:0] coef_zero;
  logic signed [15:0] coef_one;
  logic signed [15:0] coef_two;
  logic signed [15:0] wave_value;
  logic               last_sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] dual_zero;
  logic signed [31:0] dual_one;
  logic signed [31:0] dual_two;
  logic signed [47:0] back_term;
  logic               updated;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  dual_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int holds_done;
  int phase_items;
  int total_items;
  int back_items;
  int settings_used;
  int in_stall_cycles;
  bit is_loaded [MAX_SAMPLES];
  int loaded_list [$];

  moment_constraint_dual_update_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sample_index (sample_index),
    .coef_zero    (coef_zero),
    .coef_one     (coef_one),
    .coef_two     (coef_two),
    .wave_value   (wave_value),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dual_zero    (dual_zero),
    .dual_one     (dual_one),
    .dual_two     (dual_two),
    .back_term    (back_term),
    .updated      (updated),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stall, plus a long counted hold when requested
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Output monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(dual_zero, dual_one, dual_two, back_term, updated);
      if (in_valid && in_stall) in_stall_cycles++;
    end
  end

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(cmd_t op, logic [9:0] idx, coef3_t coefs,
                           logic signed [15:0] wave, logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    sample_index <= idx;
    coef_zero    <= coefs[0];
    coef_one     <= coefs[1];
    coef_two     <= coefs[2];
    wave_value   <= wave;
    last_sample  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, idx, coefs, wave, last);
    phase_items++;
    total_items++;
    if (op == CMD_BACK) back_items++;
    if (op == CMD_LOAD && !is_loaded[idx]) begin
      is_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_q14();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(32'h4000, 32'h30000);
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h80000);
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h1000, 32'h40000);
    endcase
  endfunction

  function automatic logic [9:0] pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Register setting for one phase; the first is the extremes
  task automatic apply_config(int ph);
    logic [31:0] vals [7];
    case (ph)
      0: begin
        vals[REG_RELAX]      = 32'hFFFF;
        vals[REG_STEP_ZERO]  = 32'hFFFF_FFFF;
        vals[REG_STEP_ONE]   = 32'd0;
        vals[REG_STEP_TWO]   = 32'd1;
        vals[REG_BOUND_ZERO] = 32'h7FFF_FFFF;
        vals[REG_BOUND_ONE]  = 32'h8000_0000;
        vals[REG_BOUND_TWO]  = 32'd0;
      end
      1: begin
        vals[REG_RELAX]      = RELAX_RESET;
        vals[REG_STEP_ZERO]  = STEP_RESET;
        vals[REG_STEP_ONE]   = STEP_RESET;
        vals[REG_STEP_TWO]   = STEP_RESET;
        vals[REG_BOUND_ZERO] = BOUND_RESET;
        vals[REG_BOUND_ONE]  = BOUND_RESET;
        vals[REG_BOUND_TWO]  = BOUND_RESET;
      end
      2: begin
        vals[REG_RELAX]      = 32'd0;
        vals[REG_STEP_ZERO]  = 32'h10000;
        vals[REG_STEP_ONE]   = 32'h8000;
        vals[REG_STEP_TWO]   = 32'h30000;
        vals[REG_BOUND_ZERO] = 32'h10000;
        vals[REG_BOUND_ONE]  = 32'h8000;
        vals[REG_BOUND_TWO]  = 32'h20000;
      end
      default: begin
        vals[REG_RELAX]      = (ph == 3) ? 32'd49152 : $urandom_range(0, 16'hFFFF);
        vals[REG_STEP_ZERO]  = pick_step();
        vals[REG_STEP_ONE]   = pick_step();
        vals[REG_STEP_TWO]   = pick_step();
        vals[REG_BOUND_ZERO] = pick_bound();
        vals[REG_BOUND_ONE]  = pick_bound();
        vals[REG_BOUND_TWO]  = pick_bound();
      end
    endcase
    for (int i = 0; i < 7; i++) write_reg(3'(i), vals[i]);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Stray transaction: any command, stray last flags, loaded rows only for accumulate and back-project
  task automatic send_noise();
    cmd_t op;
    op = cmd_t'($urandom_range(0, 3));
    if (op == CMD_ACCUM || op == CMD_BACK)
      send_item(op, pick_loaded(), $urandom, pick_q14(), $urandom_range(0, 1));
    else
      send_item(op, $urandom_range(0, MAX_SAMPLES - 1), {pick_q14(), pick_q14(), pick_q14()},
                $urandom, $urandom_range(0, 1));
  endtask

  // One pass: load rows, stream samples mostly ending in last, then back-project, sometimes clear
  task automatic run_pass();
    int         n;
    int         nback;
    bit         drop_last;
    logic [9:0] idx;
    logic [9:0] picks [$];
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      if (loaded_list.size() == 0 || $urandom_range(0, 99) < 60) begin
        idx = $urandom_range(0, MAX_SAMPLES - 1);
        send_item(CMD_LOAD, idx, {pick_q14(), pick_q14(), pick_q14()}, $urandom,
                  $urandom_range(0, 1));
      end else begin
        idx = pick_loaded();
      end
      picks.push_back(idx);
    end
    drop_last = ($urandom_range(0, 19) == 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8) send_noise();
      send_item(CMD_ACCUM, picks[k], $urandom, pick_q14(), (k == n - 1) && !drop_last);
    end
    nback = $urandom_range(0, 3);
    for (int k = 0; k < nback; k++)
      send_item(CMD_BACK, pick_loaded(), $urandom, $urandom, $urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0)
      send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // Main sequence
  initial begin
    bit hold_issued;
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = CMD_LOAD;
    sample_index   = '0;
    coef_zero      = '0;
    coef_one       = '0;
    coef_two       = '0;
    wave_value     = '0;
    last_sample    = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = REG_RELAX;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_issued    = 1'b0;
    total_items    = 0;
    back_items     = 0;
    settings_used  = 0;
    in_stall_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one constraint off, zero step on moment one
    write_reg(REG_RELAX, 32'd49152);
    write_reg(REG_STEP_ZERO, 32'h10000);
    write_reg(REG_STEP_ONE, 32'd0);
    write_reg(REG_STEP_TWO, 32'h28000);
    write_reg(REG_BOUND_ZERO, 32'h18000);
    write_reg(REG_BOUND_ONE, 32'd0);
    write_reg(REG_BOUND_TWO, 32'hFFFF_FFFF);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;

    // Field extremes, last flag on non-accumulate commands
    send_item(CMD_LOAD, 10'd0, {16'h0000, 16'h8000, 16'h7FFF}, 16'sh0000, 1'b0);
    send_item(CMD_LOAD, 10'd1023, {16'hFFFF, 16'h7FFF, 16'h8000}, 16'sh7FFF, 1'b0);
    send_item(CMD_LOAD, 10'd341, {16'h1234, 16'h5555, 16'h2AAA}, 16'sh8000, 1'b1);
    send_item(CMD_LOAD, 10'd682, {16'hC000, 16'h2AAA, 16'h5555}, 16'sh0000, 1'b0);
    send_item(CMD_ACCUM, 10'd0, '0, 16'sh7FFF, 1'b0);
    send_item(CMD_ACCUM, 10'd1023, '0, 16'sh8000, 1'b0);
    send_item(CMD_ACCUM, 10'd341, '0, 16'sh4000, 1'b1);
    send_item(CMD_BACK, 10'd0, '0, 16'sh0000, 1'b0);
    send_item(CMD_BACK, 10'd1023, '0, 16'sh0000, 1'b1);
    // Clear keeps the running sums
    send_item(CMD_ACCUM, 10'd0, '0, 16'sh8000, 1'b0);
    send_item(CMD_CLEAR, 10'd0, '0, 16'sh0000, 1'b1);
    send_item(CMD_ACCUM, 10'd682, '0, 16'sh7FFF, 1'b1);
    send_item(CMD_BACK, 10'd682, '0, 16'sh0000, 1'b0);
    // Repeated full-scale samples push the duals into the clamp
    repeat (2) send_item(CMD_ACCUM, 10'd1023, '0, 16'sh7FFF, 1'b0);
    send_item(CMD_ACCUM, 10'd1023, '0, 16'sh7FFF, 1'b1);
    send_item(CMD_BACK, 10'd341, '0, 16'sh0000, 1'b0);
    send_item(CMD_CLEAR, 10'd1023, '0, 16'sh7FFF, 1'b0);
    send_item(CMD_BACK, 10'd1023, '0, 16'sh0000, 1'b0);
    wait_idle();

    // Random phases: each its own register setting, and one of four idling modes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_config(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (ph == PRESSURE_PHASE && !hold_issued && phase_items >= 30) begin
          hold_req    = 1'b1;
          hold_issued = 1'b1;
        end
        run_pass();
      end
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    repeat (50) @(posedge clk);
    $display("Run covered %0d transactions under %0d register settings: %0d dual updates, %0d back-projections.",
             total_items, settings_used, sb.updates, back_items);
    $display("%0d results checked; input stalled %0d cycles, %0d long receiver hold(s).",
             sb.checked, in_stall_cycles, holds_done);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
